@@ rtl/assert_macros.svh @@
// assertion macros used by the rtl datapath
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");
`else
`define ASSERT_IMPL(label, clk, rst, ante, cons)
`define ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

@@ rtl/lz4d_pkg.sv @@
// shared types and constants of the lz4 frame decompressor
`default_nettype none
package lz4d_pkg;

   localparam int unsigned WindowBytes = 65536;
   localparam int unsigned AddrBits = $clog2(WindowBytes);
   localparam int unsigned BytesPerResultDefault = 8;
   localparam logic [31:0] LzMagic = 32'h184d2204;
   localparam logic [7:0] ExtMore = 8'hff;
   localparam logic [3:0] NibbleMax = 4'hf;
   localparam int unsigned CopyBits = 9;

   typedef enum logic [3:0] {
      PH_MAGIC, PH_FLG, PH_SKIP, PH_BSIZE, PH_RAW, PH_TOKEN, PH_LITEXT, PH_LIT,
      PH_OFF0, PH_OFF1, PH_MATCHEXT, PH_HALT
   } phase_type;

   typedef enum logic [2:0] {
      ST_DATA, ST_DONE, ST_MISMATCH, ST_MAGIC, ST_TRUNC, ST_OVER, ST_OFFSET
   } status_type;

   typedef enum logic [2:0] {
      OP_NONE, OP_BYTE, OP_READ, OP_COPY, OP_FLUSH, OP_STATUS, OP_END, OP_CLEAR
   } op_type;

   typedef enum logic [2:0] {
      CS_IDLE, CS_EXEC, CS_RDREQ, CS_RDDAT, CS_FLUSH, CS_STAT, CS_TAIL, CS_END
   } ctl_state_type;

   typedef struct packed {
      op_type op;
      logic [7:0] data;
      logic [AddrBits-1:0] offset;
      status_type code;
   } dp_cmd_type;

   typedef struct packed {
      logic busy;
      logic [31:0] out_pos;
   } dp_stat_type;

endpackage
`default_nettype wire

@@ rtl/lz4d_req_if.sv @@
// input word channel: one compressed byte per word
`default_nettype none
interface lz4d_req_if;
   logic valid;
   logic ready;
   logic [7:0] in_byte;
   logic in_last;
   modport source(output valid, output in_byte, output in_last, input ready);
   modport sink(input valid, input in_byte, input in_last, output ready);
endinterface
`default_nettype wire

@@ rtl/lz4d_rsp_if.sv @@
// result word channel: packed output bytes or a status
`default_nettype none
interface lz4d_rsp_if;
   logic valid;
   logic ready;
   logic [63:0] data_bytes;
   logic [3:0] byte_count;
   logic run_last;
   logic [2:0] status;
   modport source(output valid, output data_bytes, output byte_count, output run_last,
                  output status, input ready);
   modport sink(input valid, input data_bytes, input byte_count, input run_last,
                input status, output ready);
endinterface
`default_nettype wire

@@ rtl/lz4d_datapath.sv @@
// datapath: history store, byte packer, pending and output word registers
`default_nettype none
`include "assert_macros.svh"
module lz4d_datapath
   import lz4d_pkg::*;
#(
   parameter int unsigned BYTES_PER_RESULT = BytesPerResultDefault
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire dp_cmd_type  cmd,
   output dp_stat_type      stat,
   lz4d_rsp_if.source       rsp
);

   localparam int unsigned PackBits = 8 * BYTES_PER_RESULT;
   localparam logic [3:0] PackFull = 4'(BYTES_PER_RESULT);

   logic [7:0] hist_mem [WindowBytes];
   logic [7:0] rd_ff;
   logic [31:0] pos_ff, pos_in;
   logic [PackBits-1:0] pack_ff, pack_in, merged;
   logic [3:0] pcnt_ff, pcnt_in;
   logic pend_v_ff, pend_v_in;
   logic [63:0] pend_data_ff, pend_data_in;
   logic [3:0] pend_cnt_ff, pend_cnt_in;
   status_type pend_st_ff, pend_st_in;
   logic rsp_v_ff, rsp_v_in;
   logic [63:0] rsp_data_ff, rsp_data_in;
   logic [3:0] rsp_cnt_ff, rsp_cnt_in;
   logic rsp_last_ff, rsp_last_in;
   status_type rsp_st_ff, rsp_st_in;

   logic out_free, can_push, is_put, put_fills, busy, go;
   logic push_v, move_v, move_last;
   logic [63:0] push_data;
   logic [3:0] push_cnt;
   status_type push_st;
   logic [7:0] byte_in;
   logic [AddrBits-1:0] rd_addr;

   // handshake availability
   assign out_free = !rsp_v_ff || rsp.ready;
   assign can_push = !pend_v_ff || out_free;
   assign is_put = (cmd.op == OP_BYTE) || (cmd.op == OP_COPY);
   assign put_fills = (pcnt_ff == PackFull - 4'd1);
   assign byte_in = (cmd.op == OP_COPY) ? rd_ff : cmd.data;
   assign rd_addr = pos_ff[AddrBits-1:0] - cmd.offset;
   assign merged = pack_ff | (PackBits'(byte_in) << {pcnt_ff, 3'b000});

   // command stall
   always_comb begin
      unique case (cmd.op)
         OP_BYTE, OP_COPY: busy = put_fills && !can_push;
         OP_FLUSH:         busy = (pcnt_ff != 4'd0) && !can_push;
         OP_STATUS:        busy = !can_push;
         OP_END:           busy = pend_v_ff && !out_free;
         default:          busy = 1'b0;
      endcase
   end
   assign go = !busy;
   assign stat.busy = busy;
   assign stat.out_pos = pos_ff;

   // packer and position
   always_comb begin
      pos_in = pos_ff;
      pack_in = pack_ff;
      pcnt_in = pcnt_ff;
      push_v = 1'b0;
      push_data = '0;
      push_cnt = '0;
      push_st = ST_DATA;
      move_last = 1'b0;
      if (go) begin
         unique case (cmd.op)
            OP_BYTE, OP_COPY: begin
               pos_in = pos_ff + 32'd1;
               if (put_fills) begin
                  push_v = 1'b1;
                  push_data = 64'(merged);
                  push_cnt = PackFull;
                  pack_in = '0;
                  pcnt_in = '0;
               end else begin
                  pack_in = merged;
                  pcnt_in = pcnt_ff + 4'd1;
               end
            end
            OP_FLUSH: begin
               if (pcnt_ff != 4'd0) begin
                  push_v = 1'b1;
                  push_data = 64'(pack_ff);
                  push_cnt = pcnt_ff;
               end
               pack_in = '0;
               pcnt_in = '0;
            end
            OP_STATUS: begin
               push_v = 1'b1;
               push_st = cmd.code;
            end
            OP_END:   move_last = pend_v_ff;
            OP_CLEAR: pos_in = '0;
            default:  pos_in = pos_ff;
         endcase
      end
   end

   // pending word moves out when a newer word arrives or the step ends
   assign move_v = (push_v && pend_v_ff) || move_last;

   always_comb begin
      pend_v_in = pend_v_ff;
      pend_data_in = pend_data_ff;
      pend_cnt_in = pend_cnt_ff;
      pend_st_in = pend_st_ff;
      rsp_v_in = rsp_v_ff && !rsp.ready;
      rsp_data_in = rsp_data_ff;
      rsp_cnt_in = rsp_cnt_ff;
      rsp_last_in = rsp_last_ff;
      rsp_st_in = rsp_st_ff;
      if (move_v) begin
         rsp_v_in = 1'b1;
         rsp_data_in = pend_data_ff;
         rsp_cnt_in = pend_cnt_ff;
         rsp_st_in = pend_st_ff;
         rsp_last_in = move_last;
      end
      if (push_v) begin
         pend_v_in = 1'b1;
         pend_data_in = push_data;
         pend_cnt_in = push_cnt;
         pend_st_in = push_st;
      end else if (move_last) begin
         pend_v_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff <= '0;
         pack_ff <= '0;
         pcnt_ff <= '0;
         pend_v_ff <= 1'b0;
         rsp_v_ff <= 1'b0;
      end else begin
         pos_ff <= pos_in;
         pack_ff <= pack_in;
         pcnt_ff <= pcnt_in;
         pend_v_ff <= pend_v_in;
         rsp_v_ff <= rsp_v_in;
      end
   end

   always_ff @(posedge clock) begin
      pend_data_ff <= pend_data_in;
      pend_cnt_ff <= pend_cnt_in;
      pend_st_ff <= pend_st_in;
      rsp_data_ff <= rsp_data_in;
      rsp_cnt_ff <= rsp_cnt_in;
      rsp_last_ff <= rsp_last_in;
      rsp_st_ff <= rsp_st_in;
   end

   // history store, registered read
   always_ff @(posedge clock) begin
      if (go && is_put) begin
         hist_mem[pos_ff[AddrBits-1:0]] <= byte_in;
      end
      if (cmd.op == OP_READ) begin
         rd_ff <= hist_mem[rd_addr];
      end
   end

   assign rsp.valid = rsp_v_ff;
   assign rsp.data_bytes = rsp_data_ff;
   assign rsp.byte_count = rsp_cnt_ff;
   assign rsp.run_last = rsp_last_ff;
   assign rsp.status = rsp_st_ff;

   `ASSERT_IMPL(a_pack_below_full, clock, reset, 1'b1, pcnt_ff < PackFull)
   `ASSERT_IMPL(a_status_no_bytes, clock, reset, rsp_v_ff && (rsp_st_ff != ST_DATA), rsp_cnt_ff == 4'd0)
   `ASSERT_IMPL(a_data_has_bytes, clock, reset, rsp_v_ff && (rsp_st_ff == ST_DATA), rsp_cnt_ff != 4'd0)
   `ASSERT_NEXT(a_put_advances, clock, reset, is_put && go, pos_ff == $past(pos_ff) + 32'd1)

endmodule
`default_nettype wire

@@ rtl/lz4d_controller.sv @@
// controller: frame parser state and the step sequencer
`default_nettype none
module lz4d_controller
   import lz4d_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   lz4d_req_if.sink         req,
   input  wire logic        csr_write_enable,
   input  wire logic [31:0] csr_write_data,
   output dp_cmd_type       cmd,
   input  wire dp_stat_type stat
);

   ctl_state_type st_ff, st_in;
   phase_type phase_ff, phase_in;
   logic [31:0] fshift_ff, fshift_in;
   logic [1:0] fidx_ff, fidx_in;
   logic [3:0] skip_ff, skip_in;
   logic [2:0] flags_ff, flags_in;
   logic [30:0] bleft_ff, bleft_in;
   logic [3:0] tmatch_ff, tmatch_in;
   logic [31:0] run_ff, run_in;
   logic [AddrBits-1:0] moff_ff, moff_in;
   logic [CopyBits-1:0] copy_ff, copy_in;
   status_type code_ff, code_in;
   logic code_v_ff, code_v_in;
   logic [31:0] osize_ff;
   logic [7:0] byte_ff;
   logic last_ff;

   logic accept, put_req, do_copy, fail, endblk, lenchk, after_lit, after_match, upd;
   logic [30:0] nb;
   logic [31:0] sh, r_lit, n_chk;
   logic [AddrBits-1:0] new_off;
   logic ovf;

   assign accept = req.valid && req.ready;
   assign req.ready = (st_ff == CS_IDLE);

   // shared terms of the byte evaluation
   assign nb = bleft_ff - 31'd1;
   assign sh = fshift_ff | (32'(byte_ff) << {fidx_ff, 3'b000});
   assign r_lit = run_ff + 32'(byte_ff);
   assign new_off = {byte_ff, moff_ff[7:0]};

   // one capacity compare, operand chosen by phase
   always_comb begin
      unique case (phase_ff)
         PH_BSIZE:    n_chk = {1'b0, sh[30:0]};
         PH_TOKEN:    n_chk = 32'(byte_ff[7:4]);
         PH_LITEXT:   n_chk = r_lit;
         PH_OFF1:     n_chk = 32'(tmatch_ff) + 32'd4;
         PH_MATCHEXT: n_chk = r_lit;
         default:     n_chk = '0;
      endcase
   end
   assign ovf = (33'(stat.out_pos) + 33'(n_chk)) > 33'(osize_ff);

   // parser next values
   always_comb begin
      phase_in = phase_ff;
      fshift_in = fshift_ff;
      fidx_in = fidx_ff;
      skip_in = skip_ff;
      flags_in = flags_ff;
      bleft_in = bleft_ff;
      tmatch_in = tmatch_ff;
      run_in = run_ff;
      moff_in = moff_ff;
      copy_in = copy_ff;
      code_in = code_ff;
      code_v_in = code_v_ff;
      put_req = 1'b0;
      do_copy = 1'b0;
      fail = 1'b0;
      endblk = 1'b0;
      lenchk = 1'b0;
      after_lit = 1'b0;
      after_match = 1'b0;
      if (st_ff == CS_EXEC) begin
         code_v_in = 1'b0;
         unique case (phase_ff)
            PH_MAGIC: begin
               if (byte_ff != LzMagic[{fidx_ff, 3'b000} +: 8]) begin
                  fail = 1'b1;
                  code_in = ST_MAGIC;
               end else if (fidx_ff == 2'd3) begin
                  fidx_in = 2'd0;
                  phase_in = PH_FLG;
               end else begin
                  fidx_in = fidx_ff + 2'd1;
               end
            end
            PH_FLG: begin
               flags_in = {byte_ff[3], byte_ff[4], byte_ff[0]};
               skip_in = 4'd2 + (byte_ff[3] ? 4'd8 : 4'd0) + (byte_ff[0] ? 4'd4 : 4'd0);
               phase_in = PH_SKIP;
            end
            PH_SKIP: begin
               if (skip_ff != 4'd0) skip_in = skip_ff - 4'd1;
               if (skip_ff <= 4'd1) begin
                  phase_in = PH_BSIZE;
                  fshift_in = '0;
                  fidx_in = '0;
               end
            end
            PH_BSIZE: begin
               fshift_in = sh;
               if (fidx_ff != 2'd3) begin
                  fidx_in = fidx_ff + 2'd1;
               end else begin
                  fidx_in = 2'd0;
                  if (sh == 32'd0) begin
                     fail = 1'b1;
                     code_in = (stat.out_pos == osize_ff) ? ST_DONE : ST_MISMATCH;
                  end else begin
                     bleft_in = sh[30:0];
                     if (sh[31]) begin
                        if (ovf) begin
                           fail = 1'b1;
                           code_in = ST_OVER;
                        end else if (sh[30:0] == 31'd0) begin
                           endblk = 1'b1;
                        end else begin
                           phase_in = PH_RAW;
                        end
                     end else begin
                        phase_in = PH_TOKEN;
                     end
                  end
               end
            end
            PH_RAW: begin
               bleft_in = nb;
               put_req = 1'b1;
               if (nb == 31'd0) endblk = 1'b1;
            end
            PH_TOKEN: begin
               bleft_in = nb;
               tmatch_in = byte_ff[3:0];
               run_in = 32'(byte_ff[7:4]);
               if (byte_ff[7:4] == NibbleMax) begin
                  if (nb == 31'd0) begin
                     fail = 1'b1;
                     code_in = ST_TRUNC;
                  end else begin
                     phase_in = PH_LITEXT;
                  end
               end else begin
                  lenchk = 1'b1;
               end
            end
            PH_LITEXT: begin
               bleft_in = nb;
               run_in = r_lit;
               if (byte_ff == ExtMore) begin
                  if (r_lit > 32'(nb)) begin
                     fail = 1'b1;
                     code_in = ST_TRUNC;
                  end
               end else begin
                  lenchk = 1'b1;
               end
            end
            PH_LIT: begin
               bleft_in = nb;
               put_req = 1'b1;
               run_in = run_ff - 32'd1;
               if (run_ff == 32'd1) after_lit = 1'b1;
            end
            PH_OFF0: begin
               bleft_in = nb;
               moff_in = AddrBits'(byte_ff);
               if (nb == 31'd0) begin
                  fail = 1'b1;
                  code_in = ST_TRUNC;
               end else begin
                  phase_in = PH_OFF1;
               end
            end
            PH_OFF1: begin
               bleft_in = nb;
               moff_in = new_off;
               if ((tmatch_ff == NibbleMax) && (nb == 31'd0)) begin
                  fail = 1'b1;
                  code_in = ST_TRUNC;
               end else if ((new_off == '0) || (32'(new_off) > stat.out_pos)) begin
                  fail = 1'b1;
                  code_in = ST_OFFSET;
               end else if (tmatch_ff == NibbleMax) begin
                  run_in = 32'd19;
                  phase_in = PH_MATCHEXT;
               end else if (ovf) begin
                  fail = 1'b1;
                  code_in = ST_OVER;
               end else begin
                  do_copy = 1'b1;
                  copy_in = CopyBits'(tmatch_ff) + CopyBits'(4);
                  after_match = 1'b1;
               end
            end
            PH_MATCHEXT: begin
               bleft_in = nb;
               run_in = r_lit;
               if (ovf) begin
                  fail = 1'b1;
                  code_in = ST_OVER;
               end else begin
                  do_copy = (r_lit[CopyBits-1:0] != '0);
                  copy_in = r_lit[CopyBits-1:0];
                  run_in = '0;
                  if (byte_ff == ExtMore) begin
                     if (nb == 31'd0) begin
                        fail = 1'b1;
                        code_in = ST_TRUNC;
                     end
                  end else begin
                     after_match = 1'b1;
                  end
               end
            end
            default: phase_in = phase_ff;
         endcase

         // literal length known
         if (lenchk) begin
            if (run_in > 32'(nb)) begin
               fail = 1'b1;
               code_in = ST_TRUNC;
            end else if (ovf) begin
               fail = 1'b1;
               code_in = ST_OVER;
            end else if (run_in != 32'd0) begin
               phase_in = PH_LIT;
            end else begin
               after_lit = 1'b1;
            end
         end
         if (after_lit) begin
            if (nb == 31'd0) endblk = 1'b1;
            else phase_in = PH_OFF0;
         end
         if (after_match) begin
            if (nb == 31'd0) endblk = 1'b1;
            else phase_in = PH_TOKEN;
         end
         // block end: skip checksum or read next size
         if (endblk) begin
            if (flags_ff[1]) begin
               skip_in = 4'd4;
               phase_in = PH_SKIP;
            end else begin
               phase_in = PH_BSIZE;
               fshift_in = '0;
               fidx_in = '0;
            end
         end
         if (fail) begin
            phase_in = PH_HALT;
            code_v_in = 1'b1;
         end
      end else if (st_ff == CS_RDDAT) begin
         if (!stat.busy) copy_in = copy_ff - CopyBits'(1);
      end else if ((st_ff == CS_TAIL) && last_ff) begin
         // source end: truncation if not halted, then clear the frame
         if (phase_ff != PH_HALT) begin
            phase_in = PH_HALT;
            code_in = ST_TRUNC;
         end else begin
            phase_in = PH_MAGIC;
            fshift_in = '0;
            fidx_in = '0;
            skip_in = '0;
            flags_in = '0;
            bleft_in = '0;
            tmatch_in = '0;
            run_in = '0;
            moff_in = '0;
         end
      end
   end

   assign upd = !((st_ff == CS_EXEC) && put_req && stat.busy);

   // next state
   always_comb begin
      st_in = st_ff;
      unique case (st_ff)
         CS_IDLE:  if (accept) st_in = CS_EXEC;
         CS_EXEC:  if (upd) st_in = do_copy ? CS_RDREQ : CS_FLUSH;
         CS_RDREQ: st_in = CS_RDDAT;
         CS_RDDAT: if (!stat.busy) st_in = (copy_ff == CopyBits'(1)) ? CS_FLUSH : CS_RDREQ;
         CS_FLUSH: if (!stat.busy) st_in = code_v_ff ? CS_STAT : CS_TAIL;
         CS_STAT:  if (!stat.busy) st_in = CS_TAIL;
         CS_TAIL:  st_in = (last_ff && (phase_ff != PH_HALT)) ? CS_STAT : CS_END;
         CS_END:   if (!stat.busy) st_in = CS_IDLE;
         default:  st_in = CS_IDLE;
      endcase
   end

   // datapath commands
   always_comb begin
      cmd.data = byte_ff;
      cmd.offset = moff_ff;
      cmd.code = code_ff;
      unique case (st_ff)
         CS_EXEC:  cmd.op = put_req ? OP_BYTE : OP_NONE;
         CS_RDREQ: cmd.op = OP_READ;
         CS_RDDAT: cmd.op = OP_COPY;
         CS_FLUSH: cmd.op = OP_FLUSH;
         CS_STAT:  cmd.op = OP_STATUS;
         CS_TAIL:  cmd.op = (last_ff && (phase_ff == PH_HALT)) ? OP_CLEAR : OP_NONE;
         CS_END:   cmd.op = OP_END;
         default:  cmd.op = OP_NONE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff <= CS_IDLE;
         phase_ff <= PH_MAGIC;
         fshift_ff <= '0;
         fidx_ff <= '0;
         skip_ff <= '0;
         flags_ff <= '0;
         bleft_ff <= '0;
         tmatch_ff <= '0;
         run_ff <= '0;
         moff_ff <= '0;
         copy_ff <= '0;
         code_ff <= ST_DATA;
         code_v_ff <= 1'b0;
         osize_ff <= '0;
      end else begin
         st_ff <= st_in;
         if (csr_write_enable) osize_ff <= csr_write_data;
         if (upd) begin
            phase_ff <= phase_in;
            fshift_ff <= fshift_in;
            fidx_ff <= fidx_in;
            skip_ff <= skip_in;
            flags_ff <= flags_in;
            bleft_ff <= bleft_in;
            tmatch_ff <= tmatch_in;
            run_ff <= run_in;
            moff_ff <= moff_in;
            copy_ff <= copy_in;
            code_ff <= code_in;
            code_v_ff <= code_v_in;
         end
      end
   end

   // latched input word
   always_ff @(posedge clock) begin
      if (accept) begin
         byte_ff <= req.in_byte;
         last_ff <= req.in_last;
      end
   end

endmodule
`default_nettype wire

@@ rtl/lz4_frame_decompressor.sv @@
// Top level: an input word takes the accept, evaluate, flush, tail and finish
// steps, plus a read request and a read data step per copied match byte, set
// by the registered read of the single-port history store, a status step per
// status word, one more when the final byte ends a frame early, and stalls
// while the result side is not ready. One input word is in work at a time.
// Reset (synchronous, active high) clears parser, size and output registers.
`default_nettype none
module lz4_frame_decompressor
   import lz4d_pkg::*;
#(
   parameter int unsigned BYTES_PER_RESULT = BytesPerResultDefault
) (
   input  wire logic        clock,
   input  wire logic        reset,
   lz4d_req_if.sink         req,
   lz4d_rsp_if.source       rsp,
   input  wire logic        csr_write_enable,
   input  wire logic [31:0] csr_write_data
);

   dp_cmd_type cmd;
   dp_stat_type stat;

   // parser and sequencer
   lz4d_controller u_ctl (
      .clock(clock),
      .reset(reset),
      .req(req),
      .csr_write_enable(csr_write_enable),
      .csr_write_data(csr_write_data),
      .cmd(cmd),
      .stat(stat)
   );

   // history, packing and output
   lz4d_datapath #(
      .BYTES_PER_RESULT(BYTES_PER_RESULT)
   ) u_dp (
      .clock(clock),
      .reset(reset),
      .cmd(cmd),
      .stat(stat),
      .rsp(rsp)
   );

endmodule
`default_nettype wire
